// ===== rtl/merge_sorter_descending_defines.svh =====
// Assertion macros for the merge sorter.
// Included by modules that carry concurrent assertions; expects clk and rst in scope.
`ifndef MERGE_SORTER_DESCENDING_DEFINES_SVH
`define MERGE_SORTER_DESCENDING_DEFINES_SVH

// same-cycle implication
`define MSD_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define MSD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/msd_pkg.sv =====
// Shared types for the descending merge sorter: payload structs and sequencer states.
// No dependencies.
`default_nettype none

package msd_pkg;

  localparam int ValueWidth = 32;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         is_last;
  } item_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] sorted_value;
    logic                         last_out;
    logic                         overflow;
  } result_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PASS,
    ST_PAIR,
    ST_HEAD_A,
    ST_HEAD_B,
    ST_MERGE,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_EMIT_RD,
    ST_EMIT_WR
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/msd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module msd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/merge_sorter_descending.sv =====
// Descending merge sorter: collects signed values, sorts them in RAM, streams them out.
// Depends on msd_pkg, msd_ram and merge_sorter_descending_defines.svh.
//
// Usage:
//   item channel (item_valid/item_ready/item): one signed 32-bit value per transfer;
//   is_last closes the set. Up to MAX_ITEMS values are kept; extra ones are
//   dropped and every result of that set then carries overflow = 1.
//   result channel (result_valid/result_ready/result): the stored values in
//   descending order, last_out on the final one.
// Sequencing:
//   after the closing transfer the block runs ceil(log2 n) bottom-up merge passes
//   between two RAMs. Each run pair first reads the heads of both runs; then each
//   element is written to the other RAM while the next head is read through the
//   one read port, whose read data is registered. Emission then reads each
//   element and registers it in the result register.
//   item_ready is low from the closing transfer until the last result is
//   registered; loading of the next set may start while that result waits.
// Reset clears the count, the overflow flag and result_valid; RAM
// contents are not cleared. A stalled receiver holds the output register and
// the sequencer waits on it.
`default_nettype none

module merge_sorter_descending #(
  parameter int MAX_ITEMS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  msd_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output msd_pkg::result_t result
);

  import msd_pkg::*;

`include "merge_sorter_descending_defines.svh"

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = CW + 2;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_ITEMS);

  state_t state, state_next;

  logic [CW-1:0] count;
  logic          ovf;
  logic [PW-1:0] w, lo, mid, hi, a, b, k;
  logic [PW-1:0] n_ext, mid_c, hi_c, sum_m, sum_h;
  logic          src;
  logic signed [ValueWidth-1:0] ha, hb;

  logic                  we0, we1;
  logic [AW-1:0]         waddr, raddr;
  logic [ValueWidth-1:0] wdata, rdata0, rdata1, src_data;
  logic                  take_a, slot_free, emit_last, accept;

  msd_ram #(.WIDTH(ValueWidth), .DEPTH(MAX_ITEMS)) u_ram0 (
    .clk(clk), .we(we0), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata0)
  );

  msd_ram #(.WIDTH(ValueWidth), .DEPTH(MAX_ITEMS)) u_ram1 (
    .clk(clk), .we(we1), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata1)
  );

  assign src_data   = src ? rdata1 : rdata0;
  assign n_ext      = PW'(count);
  assign sum_m      = lo + w;
  assign sum_h      = lo + (w << 1);
  assign mid_c      = (sum_m > n_ext) ? n_ext : sum_m;
  assign hi_c       = (sum_h > n_ext) ? n_ext : sum_h;
  assign take_a     = (a < mid) && ((b >= hi) || (ha > hb));
  assign slot_free  = !result_valid || result_ready;
  assign emit_last  = (k + PW'(1)) == n_ext;
  assign item_ready = (state == ST_LOAD);
  assign accept     = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    we0        = 1'b0;
    we1        = 1'b0;
    waddr      = k[AW-1:0];
    wdata      = take_a ? ha : hb;
    raddr      = k[AW-1:0];
    case (state)
      ST_LOAD: begin
        waddr = count[AW-1:0];
        wdata = item.value;
        if (item_valid) begin
          we0 = (count < MaxCount);
          if (item.is_last) begin
            state_next = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        state_next = (w >= n_ext) ? ST_EMIT_RD : ST_PAIR;
      end
      ST_PAIR: begin
        raddr = lo[AW-1:0];
        state_next = (lo >= n_ext) ? ST_PASS : ST_HEAD_A;
      end
      ST_HEAD_A: begin
        raddr = mid[AW-1:0];
        state_next = ST_HEAD_B;
      end
      ST_HEAD_B: begin
        state_next = ST_MERGE;
      end
      ST_MERGE: begin
        if (k == hi) begin
          state_next = ST_PAIR;
        end else begin
          we0 = src;
          we1 = !src;
          if (take_a) begin
            raddr = a[AW-1:0] + AW'(1);
            state_next = ST_FETCH_A;
          end else begin
            raddr = b[AW-1:0] + AW'(1);
            state_next = ST_FETCH_B;
          end
        end
      end
      ST_FETCH_A, ST_FETCH_B: begin
        state_next = ST_MERGE;
      end
      ST_EMIT_RD: begin
        state_next = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (slot_free) begin
          state_next = emit_last ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (accept) begin
            if (count < MaxCount) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
        end
        ST_EMIT_WR: begin
          if (slot_free) begin
            result_valid <= 1'b1;
            if (emit_last) begin
              count <= '0;
              ovf   <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_LOAD: begin
        w   <= PW'(1);
        lo  <= '0;
        src <= 1'b0;
      end
      ST_PASS: begin
        k <= '0;
      end
      ST_PAIR: begin
        if (lo >= n_ext) begin
          w   <= w << 1;
          src <= !src;
          lo  <= '0;
        end else begin
          mid <= mid_c;
          hi  <= hi_c;
          a   <= lo;
          b   <= mid_c;
          k   <= lo;
        end
      end
      ST_HEAD_A: begin
        ha <= src_data;
      end
      ST_HEAD_B: begin
        hb <= src_data;
      end
      ST_MERGE: begin
        if (k == hi) begin
          lo <= hi;
        end else begin
          k <= k + PW'(1);
          if (take_a) begin
            a <= a + PW'(1);
          end else begin
            b <= b + PW'(1);
          end
        end
      end
      ST_FETCH_A: begin
        ha <= src_data;
      end
      ST_FETCH_B: begin
        hb <= src_data;
      end
      ST_EMIT_WR: begin
        if (slot_free) begin
          result.sorted_value <= src_data;
          result.last_out     <= emit_last;
          result.overflow     <= ovf;
          k                   <= k + PW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  `MSD_ASSERT_NOW(a_count_bound, 1'b1, count <= MaxCount, "element count beyond capacity")
  `MSD_ASSERT_NOW(a_ovf_full, ovf, count == MaxCount, "overflow flagged with room left")
  `MSD_ASSERT_NOW(a_merge_src, (state == ST_MERGE) && (k != hi), (a < mid) || (b < hi),
                  "merge write with both runs exhausted")
  `MSD_ASSERT_NEXT(a_merge_step, (state == ST_MERGE) && (k != hi), k == $past(k) + PW'(1),
                   "merge output pointer did not advance")

endmodule

`default_nettype wire
